>>> rtl/core/bmhq_pkg.sv
// Package for the binary min-heap queue: sizes, field types, codes and states.
// Used by binary_min_heap_queue_unit; depends on nothing.
`timescale 1ns / 1ps

package bmhq_pkg;

   localparam int CAPACITY = 1024;
   localparam int KEY_BITS = 32;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   // child index 2*i+2 of the deepest slot needs two bits over the address
   localparam int CHILD_W = ADDR_W + 2;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [CNT_W-1:0]    count_type;
   typedef logic [CHILD_W-1:0]  child_type;

   typedef enum logic [1:0] {
      MODE_INSERT  = 2'd0,
      MODE_DELETE  = 2'd1,
      MODE_APPEND  = 2'd2,
      MODE_REBUILD = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] key_in;
   } req_word_type;

   typedef struct packed {
      logic [31:0] min_key;
      logic [10:0] entry_count;
      status_type  status;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_SU_READ,
      ST_SU_CMP,
      ST_DEL_READ,
      ST_DEL_LOAD,
      ST_SD_READ,
      ST_SD_CMP,
      ST_RB_NEXT,
      ST_RB_LOAD,
      ST_RESP
   } state_type;

endpackage

>>> rtl/core/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue: key memory, sift sequencer and result register.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                  Word
// request   in         req_valid, req_stall, req_word         mode, key_in
// response  out        rsp_valid, rsp_stall, rsp_word         min_key, entry_count, status
//
// One word at a time. A full or empty request goes straight to the response, append
// writes the key at the end, insert climbs one level per parent read and compare until
// the key is not smaller than its parent or reaches the root, delete sinks the last key
// from the root, and rebuild sinks every node from count/2 - 1 down to the root.
// The steps are set by the single key memory: one read (a pair when sinking), then a
// compare-and-write, for every heap level. Reset (synchronous) empties the heap; the memory is
// not cleared. A stalled response holds in the output register while the next
// request is already taken in.

module binary_min_heap_queue_unit
   import bmhq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   // key memory: one write port, two registered read ports
   key_type    key_store [CAPACITY];
   logic       mem_we;
   addr_type   mem_wa;
   key_type    mem_wd;
   addr_type   mem_ra;
   addr_type   mem_rb;
   key_type    rd_a_ff;
   key_type    rd_b_ff;

   state_type    state_ff, state_in;
   addr_type     pos_ff, pos_in;         // current hole position
   key_type      key_ff, key_in;         // key being sifted
   key_type      min_ff, min_in;
   count_type    count_ff, count_in;
   count_type    rb_idx_ff, rb_idx_in;   // rebuild walks count/2 down to 1
   logic         rb_ff, rb_in;
   status_type   status_ff, status_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic       req_fire;
   logic       slot_free;
   logic       store_full;
   logic       store_empty;
   child_type  lc;
   child_type  rc;
   logic       sd_leaf;
   logic       pick_right;
   key_type    pick_key;
   addr_type   pick_pos;
   logic       sd_stop;
   logic       su_stop;
   addr_type   parent;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign store_full  = (count_ff >= CNT_W'(CAPACITY));
   assign store_empty = (count_ff == '0);

   // child and parent indices of the hole
   assign lc         = (CHILD_W'(pos_ff) << 1) + CHILD_W'(1);
   assign rc         = lc + CHILD_W'(1);
   assign sd_leaf    = (lc >= CHILD_W'(count_ff));
   // right child only when it exists and is strictly smaller
   assign pick_right = (rc < CHILD_W'(count_ff)) && (rd_b_ff < rd_a_ff);
   assign pick_key   = pick_right ? rd_b_ff : rd_a_ff;
   assign pick_pos   = pick_right ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
   assign sd_stop    = (key_ff <= pick_key);
   assign su_stop    = (rd_a_ff <= key_ff);
   assign parent     = (pos_ff - addr_type'(1)) >> 1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_word.mode)
                  MODE_INSERT:  state_in = store_full ? ST_RESP : ST_SU_READ;
                  MODE_APPEND:  state_in = store_full ? ST_RESP : ST_APPEND;
                  MODE_DELETE:  state_in = store_empty ? ST_RESP : ST_DEL_READ;
                  MODE_REBUILD: state_in = ST_RB_NEXT;
                  default:      state_in = ST_RESP;
               endcase
            end
         end
         ST_APPEND:   state_in = ST_RESP;
         ST_SU_READ:  state_in = (pos_ff == '0) ? ST_RESP : ST_SU_CMP;
         ST_SU_CMP:   state_in = su_stop ? ST_RESP : ST_SU_READ;
         ST_DEL_READ: state_in = ST_DEL_LOAD;
         ST_DEL_LOAD: state_in = ST_SD_READ;
         ST_SD_READ: begin
            if (sd_leaf) begin
               state_in = rb_ff ? ST_RB_NEXT : ST_RESP;
            end else begin
               state_in = ST_SD_CMP;
            end
         end
         ST_SD_CMP: begin
            if (sd_stop) begin
               state_in = rb_ff ? ST_RB_NEXT : ST_RESP;
            end else begin
               state_in = ST_SD_READ;
            end
         end
         ST_RB_NEXT:  state_in = (rb_idx_ff == '0) ? ST_RESP : ST_RB_LOAD;
         ST_RB_LOAD:  state_in = ST_SD_READ;
         ST_RESP:     state_in = slot_free ? ST_IDLE : ST_RESP;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      pos_in       = pos_ff;
      key_in       = key_ff;
      min_in       = min_ff;
      count_in     = count_ff;
      rb_idx_in    = rb_idx_ff;
      rb_in        = rb_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      mem_we       = 1'b0;
      mem_wa       = pos_ff;
      mem_wd       = key_ff;
      mem_ra       = '0;
      mem_rb       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in    = key_type'(req_word.key_in);
               min_in    = '0;
               status_in = STATUS_OK;
               rb_in     = (req_word.mode == MODE_REBUILD);
               pos_in    = count_ff[ADDR_W-1:0];
               unique case (req_word.mode) inside
                  MODE_INSERT, MODE_APPEND: begin
                     if (store_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        count_in = count_ff + count_type'(1);
                     end
                  end
                  MODE_DELETE: begin
                     if (store_empty) begin
                        status_in = STATUS_EMPTY;
                     end
                  end
                  MODE_REBUILD: rb_idx_in = count_ff >> 1;
                  default:      status_in = STATUS_OK;
               endcase
            end
         end
         ST_APPEND: begin
            mem_we = 1'b1;
         end
         ST_SU_READ: begin
            // at the root: drop the key in place
            if (pos_ff == '0) begin
               mem_we = 1'b1;
            end else begin
               mem_ra = parent;
            end
         end
         ST_SU_CMP: begin
            if (su_stop) begin
               mem_we = 1'b1;
            end else begin
               mem_we = 1'b1;
               mem_wd = rd_a_ff;
               pos_in = parent;
            end
         end
         ST_DEL_READ: begin
            mem_ra = '0;
            mem_rb = addr_type'(count_ff - count_type'(1));
         end
         ST_DEL_LOAD: begin
            min_in   = rd_a_ff;
            key_in   = rd_b_ff;
            count_in = count_ff - count_type'(1);
            pos_in   = '0;
         end
         ST_SD_READ: begin
            if (sd_leaf) begin
               mem_we = 1'b1;
            end else begin
               mem_ra = lc[ADDR_W-1:0];
               mem_rb = rc[ADDR_W-1:0];
            end
         end
         ST_SD_CMP: begin
            if (sd_stop) begin
               mem_we = 1'b1;
            end else begin
               mem_we = 1'b1;
               mem_wd = pick_key;
               pos_in = pick_pos;
            end
         end
         ST_RB_NEXT: begin
            if (rb_idx_ff != '0) begin
               pos_in    = addr_type'(rb_idx_ff - count_type'(1));
               mem_ra    = addr_type'(rb_idx_ff - count_type'(1));
               rb_idx_in = rb_idx_ff - count_type'(1);
            end
         end
         ST_RB_LOAD: begin
            key_in = rd_a_ff;
         end
         ST_RESP: begin
            // load the output register once it is free
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.min_key     = 32'(min_ff);
               rsp_word_in.entry_count = 11'(count_ff);
               rsp_word_in.status      = status_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // key memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_store[mem_wa] <= mem_wd;
      end
      rd_a_ff <= key_store[mem_ra];
      rd_b_ff <= key_store[mem_rb];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      min_ff      <= min_in;
      rb_idx_ff   <= rb_idx_in;
      rb_ff       <= rb_in;
      status_ff   <= status_in;
      rsp_word_ff <= rsp_word_in;
   end

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_wa) < 32'(CAPACITY)))
      else $error("key write outside the store");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && slot_free && status_ff == STATUS_FULL)
         |=> (rsp_word.entry_count == 11'(CAPACITY) && rsp_word.min_key == '0))
      else $error("full response without a full store");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && slot_free && status_ff == STATUS_EMPTY)
         |=> (rsp_word.entry_count == '0 && rsp_word.min_key == '0))
      else $error("empty response with stored entries");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEL_LOAD) |=> (count_ff == $past(count_ff) - count_type'(1)))
      else $error("delete did not remove one entry");
`endif

endmodule
